### sv/pabk_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared types and fixed widths for the point argmax block.
package pabk_pkg;

    // Widths of the beat fields, fixed by the interface, and the queue depth
    localparam int unsigned FIELD_BITS  = 16;
    localparam int unsigned INDEX_BITS  = 7;
    localparam int unsigned QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        MODE_XY   = 2'd0,
        MODE_YX   = 2'd1,
        MODE_DIST = 2'd2,
        MODE_NONE = 2'd3
    } t_order_mode;

    // Classification of one point, made by the front part
    typedef struct packed {
        logic first;   // opens a new set
        logic active;  // within the first MAX_POINTS of its set
        logic last;    // closes the set
    } t_ctrl;

endpackage
`default_nettype wire

### sv/pabk_point_if.sv
`timescale 1ns / 1ps
`default_nettype none
// Valid/ready channel carrying one input point per beat.
interface pabk_point_if import pabk_pkg::*; ();
    logic                          valid;
    logic                          ready;
    logic signed [FIELD_BITS-1:0]  point_x;
    logic signed [FIELD_BITS-1:0]  point_y;
    logic                          last_point;

    modport source (output valid, output point_x, output point_y, output last_point,
                    input ready);
    modport sink   (input valid, input point_x, input point_y, input last_point,
                    output ready);
endinterface
`default_nettype wire

### sv/pabk_result_if.sv
`timescale 1ns / 1ps
`default_nettype none
// Valid/ready channel carrying one result index per beat.
interface pabk_result_if import pabk_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [INDEX_BITS-1:0]  max_index;

    modport source (output valid, output max_index, input ready);
    modport sink   (input valid, input max_index, output ready);
endinterface
`default_nettype wire

### sv/point_argmax_by_key_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Streaming argmax over signed 2-D points: one point a cycle sustained while
// results are taken; the index of a set's greatest point is registered once
// its last point has passed the queue and the squares and distance stages.
// The rate is set by the compare-and-update of the stored maximum in the back
// part; a four-beat queue separates the input classifier from that compare
// pipeline. While a result waits unclaimed the compare pipeline holds, and
// the queue takes up to four more beats before the point input stalls.
module point_argmax_by_key_core import pabk_pkg::*; #(
    parameter int unsigned MAX_POINTS = 128,
    parameter int unsigned COORD_BITS = 16
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_cfg_wr_en,
    input  wire [1:0]             i_cfg_wr_data,
    pabk_point_if.sink            i_point,
    pabk_result_if.source         o_result
);

    localparam int unsigned POS_W = $clog2(MAX_POINTS);
    localparam int unsigned CTRL_W = $bits(t_ctrl);
    localparam int unsigned Q_W   = CTRL_W + POS_W + 2 * COORD_BITS;

    t_order_mode                  r_order_mode;

    logic                         w_push;
    t_ctrl                        w_f_ctrl;
    logic [POS_W-1:0]             w_f_pos;
    logic signed [COORD_BITS-1:0] w_f_x;
    logic signed [COORD_BITS-1:0] w_f_y;
    logic                         w_q_ready;
    logic                         w_q_valid;
    logic [Q_W-1:0]               w_q_data;
    logic                         w_pop;
    t_ctrl                        w_b_ctrl;
    logic [POS_W-1:0]             w_b_pos;
    logic signed [COORD_BITS-1:0] w_b_x;
    logic signed [COORD_BITS-1:0] w_b_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order_mode <= MODE_XY;
        end else if (i_cfg_wr_en) begin
            r_order_mode <= t_order_mode'(i_cfg_wr_data);
        end
    end

    pabk_front #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_point   (i_point),
        .i_q_ready (w_q_ready),
        .o_push    (w_push),
        .o_ctrl    (w_f_ctrl),
        .o_pos     (w_f_pos),
        .o_x       (w_f_x),
        .o_y       (w_f_y)
    );

    pabk_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  ({w_f_ctrl, w_f_pos, w_f_x, w_f_y}),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .o_data  (w_q_data),
        .i_pop   (w_pop)
    );

    assign {w_b_ctrl, w_b_pos, w_b_x, w_b_y} = w_q_data;

    pabk_back #(
        .COORD_BITS (COORD_BITS),
        .POS_BITS   (POS_W)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_mode    (r_order_mode),
        .i_q_valid (w_q_valid),
        .i_q_ctrl  (w_b_ctrl),
        .i_q_pos   (w_b_pos),
        .i_q_x     (w_b_x),
        .i_q_y     (w_b_y),
        .o_pop     (w_pop),
        .o_result  (o_result)
    );

endmodule
`default_nettype wire

### sv/pabk_front.sv
`timescale 1ns / 1ps
`default_nettype none
// Front part: accepts points, tracks position in the set and classifies each beat.
module pabk_front import pabk_pkg::*; #(
    parameter int unsigned MAX_POINTS = 128,
    parameter int unsigned COORD_BITS = 16,
    localparam int unsigned CNT_W     = $clog2(MAX_POINTS + 1),
    localparam int unsigned POS_W     = $clog2(MAX_POINTS)
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    pabk_point_if.sink                   i_point,
    input  wire                          i_q_ready,
    output logic                         o_push,
    output t_ctrl                        o_ctrl,
    output logic [POS_W-1:0]             o_pos,
    output logic signed [COORD_BITS-1:0] o_x,
    output logic signed [COORD_BITS-1:0] o_y
);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             w_accept;

    assign i_point.ready = i_q_ready;
    assign w_accept      = i_point.valid && i_q_ready;
    assign o_push        = w_accept;

    // low COORD_BITS of the field, zero-filled above the field when wider
    assign o_x = $signed(COORD_BITS'($unsigned(i_point.point_x)));
    assign o_y = $signed(COORD_BITS'($unsigned(i_point.point_y)));

    assign o_ctrl.first  = (r_count == '0);
    assign o_ctrl.active = (r_count < CNT_W'(MAX_POINTS));
    assign o_ctrl.last   = i_point.last_point;
    assign o_pos         = r_count[POS_W-1:0];

    always_comb begin
        n_count = r_count;
        if (w_accept) begin
            priority if (i_point.last_point) begin
                n_count = '0;
            end else if (o_ctrl.active) begin
                n_count = r_count + CNT_W'(1);
            end else begin
                // past the set limit: position holds until the last mark
                n_count = r_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_POINTS))
        else $error("point count beyond set limit");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_point.last_point |=> r_count == '0)
        else $error("set position not cleared after last point");

endmodule
`default_nettype wire

### sv/pabk_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// Short FIFO decoupling the front and back parts.
module pabk_queue import pabk_pkg::*; #(
    parameter int unsigned WIDTH = 8
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_push,
    input  wire [WIDTH-1:0]  i_data,
    output logic             o_ready,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data,
    input  wire              i_pop
);

    localparam int unsigned PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int unsigned FILL_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0]  r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [FILL_W-1:0] r_fill;
    logic              w_push;
    logic              w_pop;

    assign o_ready = (r_fill != FILL_W'(QUEUE_DEPTH));
    assign o_valid = (r_fill != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign w_push  = i_push && o_ready;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            unique case ({w_push, w_pop})
                2'b10:   r_fill <= r_fill + FILL_W'(1);
                2'b01:   r_fill <= r_fill - FILL_W'(1);
                default: r_fill <= r_fill;
            endcase
        end
    end

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FILL_W'(QUEUE_DEPTH))
        else $error("queue overfilled");

    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill == '0 || r_fill == FILL_W'(QUEUE_DEPTH)) |-> r_wr_ptr == r_rd_ptr)
        else $error("queue pointers disagree with fill level");

endmodule
`default_nettype wire

### sv/pabk_back.sv
`timescale 1ns / 1ps
`default_nettype none
// Back part: squares, distance sum, compare against the stored best and result register.
module pabk_back import pabk_pkg::*; #(
    parameter int unsigned COORD_BITS = 16,
    parameter int unsigned POS_BITS   = 7
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  t_order_mode                  i_mode,
    input  wire                          i_q_valid,
    input  t_ctrl                        i_q_ctrl,
    input  wire [POS_BITS-1:0]           i_q_pos,
    input  wire signed [COORD_BITS-1:0]  i_q_x,
    input  wire signed [COORD_BITS-1:0]  i_q_y,
    output logic                         o_pop,
    pabk_result_if.source                o_result
);

    localparam int unsigned SQ_W   = 2 * COORD_BITS - 1;
    localparam int unsigned DIST_W = 2 * COORD_BITS;

    // stage 1: squares
    logic                         r_s1_valid;
    t_ctrl                        r_s1_ctrl;
    logic [POS_BITS-1:0]          r_s1_pos;
    logic signed [COORD_BITS-1:0] r_s1_x;
    logic signed [COORD_BITS-1:0] r_s1_y;
    logic [SQ_W-1:0]              r_s1_xx;
    logic [SQ_W-1:0]              r_s1_yy;
    // stage 2: distance
    logic                         r_s2_valid;
    t_ctrl                        r_s2_ctrl;
    logic [POS_BITS-1:0]          r_s2_pos;
    logic signed [COORD_BITS-1:0] r_s2_x;
    logic signed [COORD_BITS-1:0] r_s2_y;
    logic [DIST_W-1:0]            r_s2_dist;
    // stored maximum
    logic signed [COORD_BITS-1:0] r_best_x;
    logic signed [COORD_BITS-1:0] r_best_y;
    logic [DIST_W-1:0]            r_best_dist;
    logic [POS_BITS-1:0]          r_best_pos;
    // result register
    logic                         r_out_valid;
    logic [INDEX_BITS-1:0]        r_out_index;

    logic signed [DIST_W-1:0]     w_xx_full;
    logic signed [DIST_W-1:0]     w_yy_full;
    logic                         w_adv;
    logic                         w_step;
    logic                         w_x_gt, w_x_eq, w_y_gt, w_y_eq, w_d_gt, w_d_eq;
    logic                         w_ge;
    logic                         w_take;
    logic [POS_BITS-1:0]          w_sel_pos;

    // whole pipe moves unless a finished result is still waiting
    assign w_adv  = !r_out_valid || o_result.ready;
    assign o_pop  = w_adv && i_q_valid;
    assign w_step = w_adv && r_s2_valid;

    assign w_xx_full = i_q_x * i_q_x;
    assign w_yy_full = i_q_y * i_q_y;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_ctrl <= i_q_ctrl;
            r_s1_pos  <= i_q_pos;
            r_s1_x    <= i_q_x;
            r_s1_y    <= i_q_y;
            r_s1_xx   <= w_xx_full[SQ_W-1:0];
            r_s1_yy   <= w_yy_full[SQ_W-1:0];
            r_s2_ctrl <= r_s1_ctrl;
            r_s2_pos  <= r_s1_pos;
            r_s2_x    <= r_s1_x;
            r_s2_y    <= r_s1_y;
            r_s2_dist <= {1'b0, r_s1_xx} + {1'b0, r_s1_yy};
        end
    end

    assign w_x_gt = r_s2_x > r_best_x;
    assign w_x_eq = r_s2_x == r_best_x;
    assign w_y_gt = r_s2_y > r_best_y;
    assign w_y_eq = r_s2_y == r_best_y;
    assign w_d_gt = r_s2_dist > r_best_dist;
    assign w_d_eq = r_s2_dist == r_best_dist;

    // in the key modes greater or equal replaces, so the last of equal points wins; MODE_NONE never replaces
    always_comb begin
        unique case (i_mode)
            MODE_XY:   w_ge = w_x_gt || (w_x_eq && (w_y_gt || w_y_eq));
            MODE_YX:   w_ge = w_y_gt || (w_y_eq && (w_x_gt || w_x_eq));
            MODE_DIST: w_ge = w_d_gt || (w_d_eq &&
                              (w_x_gt || (w_x_eq && (w_y_gt || w_y_eq))));
            MODE_NONE: w_ge = 1'b0;
        endcase
    end

    assign w_take    = r_s2_ctrl.first || (r_s2_ctrl.active && w_ge);
    assign w_sel_pos = w_take ? r_s2_pos : r_best_pos;

    always_ff @(posedge i_clk) begin
        if (w_step && w_take) begin
            r_best_x    <= r_s2_x;
            r_best_y    <= r_s2_y;
            r_best_dist <= r_s2_dist;
            r_best_pos  <= r_s2_pos;
        end
        if (w_step && r_s2_ctrl.last) begin
            r_out_index <= INDEX_BITS'(w_sel_pos);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_adv) begin
                r_s1_valid <= i_q_valid;
                r_s2_valid <= r_s1_valid;
            end
            priority if (w_step && r_s2_ctrl.last) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end else begin
                r_out_valid <= r_out_valid;
            end
        end
    end

    assign o_result.valid     = r_out_valid;
    assign o_result.max_index = r_out_index;

    a_first_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step && r_s2_ctrl.first |=> r_best_pos == '0)
        else $error("first point of a set not stored at position zero");

    a_last_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step && r_s2_ctrl.last |=> r_out_valid)
        else $error("last point of a set gave no result");

endmodule
`default_nettype wire

### verif/pabk_argmax_monitor.sv
`timescale 1ns / 1ps
// Watches the point and result channels, predicts each set's max_index and compares.
module pabk_argmax_monitor import pabk_pkg::*; #(
    parameter int unsigned MAX_POINTS = 128
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_wr_en,
    input  wire [1:0]  i_cfg_wr_data,
    pabk_point_if      i_point,
    pabk_result_if     i_result,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_checked
);

    t_order_mode                  order_mode;
    logic signed [FIELD_BITS-1:0] best_x;
    logic signed [FIELD_BITS-1:0] best_y;
    logic [INDEX_BITS-1:0]        best_pos;
    int unsigned                  taken;
    logic [INDEX_BITS-1:0]        index_queue[$];

    function automatic int order3(input longint a, input longint b);
        if (a > b) return 1;
        if (a < b) return -1;
        return 0;
    endfunction

    // True when the new point is greater than or equal to the stored one.
    function automatic bit displaces(input logic signed [FIELD_BITS-1:0] nx, ny, bx, by,
                                     input t_order_mode mode);
        int r;
        r = 0;
        case (mode)
            MODE_XY: begin
                r = order3(nx, bx);
                if (r == 0) r = order3(ny, by);
            end
            MODE_YX: begin
                r = order3(ny, by);
                if (r == 0) r = order3(nx, bx);
            end
            MODE_DIST: begin
                r = order3(longint'(nx) * nx + longint'(ny) * ny,
                           longint'(bx) * bx + longint'(by) * by);
                if (r == 0) r = order3(nx, bx);
                if (r == 0) r = order3(ny, by);
            end
            default: return 1'b0;   // unknown key never replaces
        endcase
        return r >= 0;
    endfunction

    always @(posedge i_clk) begin
        logic [INDEX_BITS-1:0] want;
        if (!i_rst_n) begin
            order_mode   = MODE_XY;
            best_x       = '0;
            best_y       = '0;
            best_pos     = '0;
            taken        = 0;
            index_queue.delete();
            o_fail_count = 0;
            o_pending    = 0;
            o_checked    = 0;
        end else begin
            // result first, so a stray beat cannot hide behind a new expectation
            if (i_result.valid && i_result.ready) begin
                o_checked++;
                if (index_queue.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: max_index beat with nothing expected: expected none, got %0d",
                             $time, i_result.max_index);
                end else begin
                    want = index_queue.pop_front();
                    if (i_result.max_index !== want) begin
                        o_fail_count++;
                        $display("%0t: max_index mismatch: expected %0d, got %0d",
                                 $time, want, i_result.max_index);
                    end
                end
            end
            if (i_point.valid && i_point.ready) begin
                if (taken == 0) begin
                    best_x   = i_point.point_x;
                    best_y   = i_point.point_y;
                    best_pos = '0;
                    taken    = 1;
                end else if (taken < MAX_POINTS) begin
                    if (displaces(i_point.point_x, i_point.point_y, best_x, best_y,
                                  order_mode)) begin
                        best_x   = i_point.point_x;
                        best_y   = i_point.point_y;
                        best_pos = INDEX_BITS'(taken);
                    end
                    taken++;
                end
                // points past MAX_POINTS are not compared, but a last mark still closes
                if (i_point.last_point) begin
                    index_queue.push_back(best_pos);
                    taken = 0;
                end
            end
            if (i_cfg_wr_en)
                order_mode = t_order_mode'(i_cfg_wr_data);
            o_pending = index_queue.size();
        end
    end

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// Top of the argmax core testbench: clock, reset, point stimulus, mode changes and verdict.
module testbench;
    import pabk_pkg::*;

    localparam int PHASE_ITEMS = 300;
    localparam int CALM_PHASE  = 3;

    logic       i_clk;
    logic       i_rst_n;
    logic       cfg_wr_en;
    logic [1:0] cfg_wr_data;

    pabk_point_if  point_ch ();
    pabk_result_if result_ch ();

    int fail_count;
    int pending_count;
    int results_checked;
    int points_sent;
    int sets_sent;
    int mode_writes;
    bit calm;

    t_order_mode phase_modes [6] = '{MODE_XY, MODE_YX, MODE_DIST, MODE_NONE, MODE_DIST, MODE_XY};

    point_argmax_by_key_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_point       (point_ch.sink),
        .o_result      (result_ch.source)
    );

    pabk_argmax_monitor monitor_u (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_point       (point_ch),
        .i_result      (result_ch),
        .o_fail_count  (fail_count),
        .o_pending     (pending_count),
        .o_checked     (results_checked)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // result side: stalls at random except through the calm phase
    initial begin
        result_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            result_ch.ready <= i_rst_n && (calm || ($urandom_range(0, 99) >= 16));
        end
    end

    function automatic logic signed [FIELD_BITS-1:0] pick_coord();
        int v;
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 5))
                    0: v = -32768;
                    1: v = -32767;
                    2: v = -1;
                    3: v = 0;
                    4: v = 32766;
                    default: v = 32767;
                endcase
            end
            1, 2, 3, 4: v = int'($urandom_range(0, 8)) - 4;   // near the origin: many ties
            default: v = int'($urandom());
        endcase
        return FIELD_BITS'(v);
    endfunction

    task automatic send_point(input logic signed [FIELD_BITS-1:0] x, y, input logic last);
        int gap;
        if (!calm && $urandom_range(0, 99) < 16) begin
            point_ch.valid <= 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(posedge i_clk);
        end
        point_ch.valid      <= 1'b1;
        point_ch.point_x    <= x;
        point_ch.point_y    <= y;
        point_ch.last_point <= last;
        do @(posedge i_clk); while (!point_ch.ready);
        points_sent++;
    endtask

    task automatic send_random_set(input int len);
        logic signed [FIELD_BITS-1:0] x;
        logic signed [FIELD_BITS-1:0] y;
        x = '0;
        y = '0;
        for (int k = 0; k < len; k++) begin
            // now and then repeat the previous point, so equal points meet
            if (k == 0 || $urandom_range(0, 7) != 0) begin
                x = pick_coord();
                y = pick_coord();
            end
            send_point(x, y, k == len - 1);
        end
        sets_sent++;
    endtask

    // Stop sending and let every outstanding index come back, plus pipeline slack.
    task automatic wait_drained();
        int guard;
        guard = 0;
        point_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0 && guard < 5000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (12) @(posedge i_clk);
    endtask

    task automatic write_mode(input t_order_mode mode);
        wait_drained();
        cfg_wr_data <= mode;
        cfg_wr_en   <= 1'b1;
        @(posedge i_clk);
        cfg_wr_en   <= 1'b0;
        mode_writes++;
    endtask

    initial begin
        int len;
        int phase_items;
        int set_no;
        bit long_done;
        i_rst_n             <= 1'b0;
        cfg_wr_en           <= 1'b0;
        cfg_wr_data         <= MODE_XY;
        point_ch.valid      <= 1'b0;
        point_ch.point_x    <= '0;
        point_ch.point_y    <= '0;
        point_ch.last_point <= 1'b0;
        calm        = 1'b0;
        points_sent = 0;
        sets_sent   = 0;
        mode_writes = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // x-then-y from reset: single-point set, coordinate extremes, equal points
        send_point(32767, -32768, 1'b1);
        send_point(-32768, -32768, 1'b0);
        send_point(32767, -32768, 1'b0);
        send_point(32767, 32767, 1'b0);
        send_point(0, 0, 1'b0);
        send_point(-1, 32767, 1'b1);
        send_point(5, 5, 1'b0);
        send_point(5, 5, 1'b0);
        send_point(5, 5, 1'b1);
        sets_sent += 3;

        write_mode(MODE_YX);
        send_point(0, 0, 1'b0);
        send_point(-32768, 32767, 1'b0);
        send_point(32767, 32767, 1'b0);
        send_point(100, -5, 1'b1);

        // equal distances, decided by x and then y; then the largest distance
        write_mode(MODE_DIST);
        send_point(3, 4, 1'b0);
        send_point(4, 3, 1'b0);
        send_point(-5, 0, 1'b0);
        send_point(0, 5, 1'b0);
        send_point(4, -3, 1'b1);
        send_point(32767, 32767, 1'b0);
        send_point(-32768, -32768, 1'b1);

        // unknown key: first point stays
        write_mode(MODE_NONE);
        send_point(1, 1, 1'b0);
        send_point(100, 100, 1'b0);
        send_point(-5, 7, 1'b1);
        sets_sent += 4;

        foreach (phase_modes[p]) begin
            write_mode(phase_modes[p]);
            calm        = (p == CALM_PHASE);
            phase_items = 0;
            set_no      = 0;
            long_done   = 1'b0;
            while (phase_items < PHASE_ITEMS) begin
                if (!long_done && phase_items >= PHASE_ITEMS / 2) begin
                    len       = $urandom_range(125, 140);   // up to and past MAX_POINTS
                    long_done = 1'b1;
                end else if ($urandom_range(0, 19) == 0) begin
                    len = $urandom_range(13, 60);
                end else begin
                    len = $urandom_range(1, 12);
                end
                send_random_set(len);
                phase_items += len;
                set_no++;
                if ((p == 0 && set_no == 5) || $urandom_range(0, 39) == 0)
                    wait_drained();
            end
        end
        calm = 1'b0;

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (pending_count != 0)
            $display("%0t: %0d expected indices never arrived", $time, pending_count);
        $display("Run: %0d points in %0d sets, %0d mode writes, %0d indices compared",
                 points_sent, sets_sent, mode_writes, results_checked);
        $display("Keys x-y, y-x, distance and invalid; sets of 1 to 140 points, ties and extremes");
        if (fail_count == 0 && pending_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
